FILE: rtl/chist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_pkg
// Shared sizes, codes and control structs of the channel histogram block.
// ----------------------------------------------------------------------------
package chist_pkg;

    // Histogram geometry
    localparam int NUM_BINS       = 256;
    localparam int NUM_CHANNELS   = 3;
    localparam int COUNT_BITS     = 24;
    localparam int BIN_BITS       = $clog2(NUM_BINS);

    // Port field widths
    localparam int OUT_CHANNELS   = 3;
    localparam int OP_BITS        = 2;
    localparam int SAMPLE_BITS    = 8;
    localparam int OUT_COUNT_BITS = 24;
    localparam int CANVAS_BITS    = 10;
    localparam int BAR_BITS       = 10;

    // Bar scaling: count * canvas / peak, quotient never exceeds the canvas
    localparam int PROD_BITS      = COUNT_BITS + CANVAS_BITS;
    localparam int QUO_BITS       = CANVAS_BITS;
    localparam int STEP_BITS      = $clog2(QUO_BITS);

    // Configuration port
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 10;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS = 1'd1;
    localparam logic [CANVAS_BITS-1:0]  CANVAS_RESET = 10'd125;

    // Item operation codes
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_PIXEL = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(NUM_BINS - 1);

    // Controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                clr_we;
        logic [BIN_BITS-1:0] clr_addr;
        logic                peak_clr;
        logic                pix_we;
        logic                prod_load;
        logic                div_load;
        logic                out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

FILE: rtl/chist_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_if
// Valid/ready channels of the histogram block: items, results, register writes.
// ----------------------------------------------------------------------------
interface chist_req_if;
    import chist_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     op;
    logic [SAMPLE_BITS-1:0] chan0_value;
    logic [SAMPLE_BITS-1:0] chan1_value;
    logic [SAMPLE_BITS-1:0] chan2_value;
    logic [SAMPLE_BITS-1:0] bin_index;

    modport source (output valid, op, chan0_value, chan1_value, chan2_value, bin_index,
                    input ready);
    modport sink   (input valid, op, chan0_value, chan1_value, chan2_value, bin_index,
                    output ready);
endinterface

interface chist_rsp_if;
    import chist_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OUT_COUNT_BITS-1:0] count0;
    logic [OUT_COUNT_BITS-1:0] count1;
    logic [OUT_COUNT_BITS-1:0] count2;
    logic [OUT_COUNT_BITS-1:0] peak0;
    logic [OUT_COUNT_BITS-1:0] peak1;
    logic [OUT_COUNT_BITS-1:0] peak2;
    logic [BAR_BITS-1:0]       bar0;
    logic [BAR_BITS-1:0]       bar1;
    logic [BAR_BITS-1:0]       bar2;
    logic [OUT_CHANNELS-1:0]   zero_peak;

    modport source (output valid, count0, count1, count2, peak0, peak1, peak2,
                    bar0, bar1, bar2, zero_peak, input ready);
    modport sink   (input valid, count0, count1, count2, peak0, peak1, peak2,
                    bar0, bar1, bar2, zero_peak, output ready);
endinterface

interface chist_cfg_if;
    import chist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/chist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chist_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/chist_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_div
// Restoring divider for the bar height, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chist_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [chist_pkg::PROD_BITS-1:0]  dividend,
    input  logic [chist_pkg::COUNT_BITS-1:0] divisor,
    output logic [chist_pkg::QUO_BITS-1:0]   quotient,
    output logic                             done
);
    import chist_pkg::*;

    logic                  busy_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]   low_reg;
    logic [QUO_BITS-1:0]   quo_reg;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    // Trial subtract of the next partial remainder
    always_comb
    begin
        trial = {rem_reg, low_reg[QUO_BITS-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // Step sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_BITS'(QUO_BITS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient; the high dividend bits start below the divisor
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= dividend[PROD_BITS-1:QUO_BITS];
            low_reg <= dividend[QUO_BITS-1:0];
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            low_reg <= {low_reg[QUO_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_BITS-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = ~busy_reg;
endmodule

FILE: rtl/chist_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_dp
// Histogram datapath: bin RAMs, peaks, bar scaling, config and result registers.
// ----------------------------------------------------------------------------
module chist_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  chist_pkg::cmd_t                      cmd,
    output chist_pkg::status_t                   status,
    input  logic [chist_pkg::OP_BITS-1:0]        op,
    input  logic [chist_pkg::SAMPLE_BITS-1:0]    chan0_value,
    input  logic [chist_pkg::SAMPLE_BITS-1:0]    chan1_value,
    input  logic [chist_pkg::SAMPLE_BITS-1:0]    chan2_value,
    input  logic [chist_pkg::SAMPLE_BITS-1:0]    bin_index,
    input  logic                                 cfg_we,
    input  logic [chist_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [chist_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output logic [chist_pkg::OUT_CHANNELS-1:0][chist_pkg::OUT_COUNT_BITS-1:0] counts,
    output logic [chist_pkg::OUT_CHANNELS-1:0][chist_pkg::OUT_COUNT_BITS-1:0] peaks,
    output logic [chist_pkg::OUT_CHANNELS-1:0][chist_pkg::BAR_BITS-1:0]       bars,
    output logic [chist_pkg::OUT_CHANNELS-1:0]                                zero_peak
);
    import chist_pkg::*;

    logic                   mode_reg;
    logic [CANVAS_BITS-1:0] canvas_reg;
    logic                   in_range_reg;
    logic [SAMPLE_BITS-1:0] sample [OUT_CHANNELS];
    logic [BIN_BITS-1:0]    rd_bin;
    logic                   rd_in_range;
    logic [NUM_CHANNELS-1:0] div_done;

    assign sample[0] = chan0_value;
    assign sample[1] = chan1_value;
    assign sample[2] = chan2_value;

    assign rd_bin      = bin_index[BIN_BITS-1:0];
    assign rd_in_range = ({1'b0, bin_index} < (SAMPLE_BITS + 1)'(NUM_BINS));

    assign status.div_done = &div_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            canvas_reg <= CANVAS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_CANVAS: canvas_reg <= cfg_data[CANVAS_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Hold the range check of a read bin
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_range_reg <= rd_in_range;
        end
    end

    for (genvar c = 0; c < OUT_CHANNELS; c++)
    begin : g_chan
        if (c < NUM_CHANNELS)
        begin : g_built
            logic [BIN_BITS-1:0]       pix_bin;
            logic [BIN_BITS-1:0]       raddr;
            logic [BIN_BITS-1:0]       addr_reg;
            logic                      act_reg;
            logic [COUNT_BITS-1:0]     rdata;
            logic [COUNT_BITS-1:0]     bumped;
            logic                      we;
            logic [BIN_BITS-1:0]       waddr;
            logic [COUNT_BITS-1:0]     wdata;
            logic [COUNT_BITS-1:0]     peak_reg;
            logic [COUNT_BITS-1:0]     cnt_reg;
            logic [PROD_BITS-1:0]      prod_reg;
            logic [QUO_BITS-1:0]       quotient;
            logic [OUT_COUNT_BITS-1:0] cnt_o_reg;
            logic [OUT_COUNT_BITS-1:0] pk_o_reg;
            logic [BAR_BITS-1:0]       bar_o_reg;
            logic                      zp_o_reg;
            logic                      bar_zero;

            // Samples past the last bin land in the last bin
            assign pix_bin = ({1'b0, sample[c]} >= (SAMPLE_BITS + 1)'(NUM_BINS)) ?
                             LAST_BIN : sample[c][BIN_BITS-1:0];
            assign raddr   = (op == OP_READ) ? rd_bin : pix_bin;

            // Saturating increment and write mux (sweep writes zeros)
            assign bumped = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
            assign we     = cmd.clr_we | (cmd.pix_we & act_reg);
            assign waddr  = cmd.clr_we ? cmd.clr_addr : addr_reg;
            assign wdata  = cmd.clr_we ? '0 : bumped;

            chist_ram #(
                .WIDTH (COUNT_BITS),
                .DEPTH (NUM_BINS)
            ) u_ram (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (wdata),
                .raddr (raddr),
                .rdata (rdata)
            );

            // Capture item address and channel activity
            always_ff @(posedge clk)
            begin
                if (cmd.capture)
                begin
                    addr_reg <= raddr;
                    act_reg  <= (c == 0) ? 1'b1 : mode_reg;
                end
            end

            // Running peak over every bin but the last
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    peak_reg <= '0;
                end
                else if (cmd.peak_clr)
                begin
                    peak_reg <= '0;
                end
                else if (cmd.pix_we && act_reg && (addr_reg != LAST_BIN) &&
                         (bumped > peak_reg))
                begin
                    peak_reg <= bumped;
                end
            end

            // Count and scaled product for a read
            always_ff @(posedge clk)
            begin
                if (cmd.prod_load)
                begin
                    cnt_reg  <= in_range_reg ? rdata : '0;
                    prod_reg <= PROD_BITS'(rdata) * PROD_BITS'(canvas_reg);
                end
            end

            chist_div u_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (cmd.div_load),
                .dividend (prod_reg),
                .divisor  (peak_reg),
                .quotient (quotient),
                .done     (div_done[c])
            );

            assign bar_zero = (peak_reg == '0) || !in_range_reg || (addr_reg == LAST_BIN);

            // Result register
            always_ff @(posedge clk)
            begin
                if (cmd.out_load)
                begin
                    cnt_o_reg <= OUT_COUNT_BITS'(cnt_reg);
                    pk_o_reg  <= OUT_COUNT_BITS'(peak_reg);
                    bar_o_reg <= bar_zero ? '0 : BAR_BITS'(quotient);
                    zp_o_reg  <= (peak_reg == '0);
                end
            end

            assign counts[c]    = cnt_o_reg;
            assign peaks[c]     = pk_o_reg;
            assign bars[c]      = bar_o_reg;
            assign zero_peak[c] = zp_o_reg;
        end
        else
        begin : g_absent
            // Channel not built: nothing counted, peak reads as zero
            assign counts[c]    = '0;
            assign peaks[c]     = '0;
            assign bars[c]      = '0;
            assign zero_peak[c] = 1'b1;
        end
    end
endmodule

FILE: rtl/chist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chist_ctrl
// Controller: clearing sweep, item sequencing and result register handshake.
// ----------------------------------------------------------------------------
module chist_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [chist_pkg::OP_BITS-1:0] op,
    output logic                          req_ready,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output chist_pkg::cmd_t               cmd,
    input  chist_pkg::status_t            status
);
    import chist_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX,
        S_RDWAIT,
        S_DIVLD,
        S_DIV,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [BIN_BITS-1:0] clr_addr_reg;
    logic [BIN_BITS-1:0] clr_addr_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid & req_ready;
    assign rsp_valid = rsp_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cmd           = '0;
        cmd.clr_addr  = clr_addr_reg;
        cmd.capture   = accept;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we    = 1'b1;
                cmd.peak_clr  = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_BIN)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        OP_PIXEL: state_next = S_PIX;
                        OP_READ:  state_next = S_RDWAIT;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_PIX:
            begin
                cmd.pix_we = 1'b1;
                state_next = S_IDLE;
            end
            S_RDWAIT:
            begin
                cmd.prod_load = 1'b1;
                state_next    = S_DIVLD;
            end
            S_DIVLD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Result valid: set on load, drop once taken
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // State and registered outputs; reset starts with a clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end
endmodule

FILE: rtl/channel_histogram_with_bar_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_histogram_with_bar_scale
// Per-channel bin histograms with running peaks and scaled bar heights.
//
//   port  dir   beat
//   req   in    op, chan0_value..chan2_value, bin_index
//   rsp   out   count0..2, peak0..2, bar0..2, zero_peak (read items only)
//   cfg   in    index, data (0: three_channel_mode, 1: canvas_height)
//
// A pixel is a read of the bin RAMs, then a saturating write back.
// A read runs the RAM read, the count times canvas multiply, then the
// 10-step bar divider, and loads the result register.
// A clear, and reset, run a sweep of zeros through all 256 bins of the bin RAMs;
// req is not ready during it, cfg writes are always taken.
// One item is worked on at a time; a waiting result does not stall pixels,
// only the next read.
// ----------------------------------------------------------------------------
module channel_histogram_with_bar_scale (
    input  logic         clk,
    input  logic         rst_n,
    chist_req_if.sink    req,
    chist_rsp_if.source  rsp,
    chist_cfg_if.sink    cfg
);
    import chist_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [OUT_CHANNELS-1:0][OUT_COUNT_BITS-1:0] counts;
    logic [OUT_CHANNELS-1:0][OUT_COUNT_BITS-1:0] peaks;
    logic [OUT_CHANNELS-1:0][BAR_BITS-1:0]       bars;
    logic [OUT_CHANNELS-1:0]                     zero_peak;

    // Register writes are taken on any cycle
    assign cfg.ready = 1'b1;

    chist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .op        (req.op),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    chist_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .op          (req.op),
        .chan0_value (req.chan0_value),
        .chan1_value (req.chan1_value),
        .chan2_value (req.chan2_value),
        .bin_index   (req.bin_index),
        .cfg_we      (cfg.valid & cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .counts      (counts),
        .peaks       (peaks),
        .bars        (bars),
        .zero_peak   (zero_peak)
    );

    assign rsp.count0    = counts[0];
    assign rsp.count1    = counts[1];
    assign rsp.count2    = counts[2];
    assign rsp.peak0     = peaks[0];
    assign rsp.peak1     = peaks[1];
    assign rsp.peak2     = peaks[2];
    assign rsp.bar0      = bars[0];
    assign rsp.bar1      = bars[1];
    assign rsp.bar2      = bars[2];
    assign rsp.zero_peak = zero_peak;

    // No item is taken while the clearing sweep writes the RAMs
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !cmd.clr_we)
        else $error("item accepted during clearing sweep");

    // A result is loaded only once the divider has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.div_done)
        else $error("result loaded while divider busy");

    // Divider is busy in the cycle after a load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> !status.div_done)
        else $error("divider did not start");

    // A bin write-back follows an accepted pixel item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_we |-> $past(req.valid && req.ready && (req.op == OP_PIXEL)))
        else $error("bin write without a pixel item");
endmodule
